// ===== hdl/rdj_pkg.sv =====
// types and constants shared by the radial distortion datapath
`default_nettype none

package rdj_pkg;

   localparam int FIELD_WIDTH     = 24;
   localparam int OUT_WIDTH       = 32;
   localparam int INT_WIDTH       = 63;
   localparam int INT_FRAC_BITS   = 32;
   localparam int COEFF_FRAC_BITS = 20;
   localparam int OUT_FRAC_BITS   = 24;
   localparam int OUT_SHIFT       = INT_FRAC_BITS - OUT_FRAC_BITS;
   localparam int OUT_ROUND       = 1 << (OUT_SHIFT - 1);
   localparam int LIMB_WIDTH      = 32;
   localparam int CSR_INDEX_WIDTH = 4;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEFF_K1 = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COEFF_K2 = CSR_INDEX_WIDTH'(1);

   localparam logic signed [FIELD_WIDTH-1:0] COEFF_RESET =
      FIELD_WIDTH'(1) << COEFF_FRAC_BITS;

   localparam logic [INT_WIDTH-2:0] LIMIT_MAG = '1;
   localparam logic signed [INT_WIDTH-1:0] INT_LIMIT = {1'b0, LIMIT_MAG};
   localparam logic signed [INT_WIDTH-1:0] ONE_Q = INT_WIDTH'(1) << INT_FRAC_BITS;

   localparam logic [OUT_WIDTH-1:0] OUT_MAX_POS = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic [OUT_WIDTH-1:0] OUT_MAX_NEG = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] point_x;
      logic signed [FIELD_WIDTH-1:0] point_y;
   } rdj_req_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] dist_x;
      logic signed [OUT_WIDTH-1:0] dist_y;
      logic signed [OUT_WIDTH-1:0] dx_dk1;
      logic signed [OUT_WIDTH-1:0] dx_dk2;
      logic signed [OUT_WIDTH-1:0] dy_dk1;
      logic signed [OUT_WIDTH-1:0] dy_dk2;
      logic signed [OUT_WIDTH-1:0] jac_xx;
      logic signed [OUT_WIDTH-1:0] jac_xy;
      logic signed [OUT_WIDTH-1:0] jac_yy;
   } rdj_rsp_type;

   typedef struct packed {
      logic prod;
      logic sum;
      logic sat;
   } rdj_mul_en_type;

endpackage

`default_nettype wire

// ===== hdl/radial_distortion_with_jacobians.sv =====
// radial lens distortion (k1, k2) with parameter and point jacobians
//
//  port   dir  payload              handshake
//  req    in   rdj_req_type         req_valid / req_stall
//  rsp    out  rdj_rsp_type         rsp_valid / rsp_stall
//  csr    in   index, 24-bit data   csr_wr_en
//
// one transfer per cycle sustained while rsp_stall is low; a request passes every stage below before rsp valid
// four multiplier groups of three stages (partial products, sum, saturate), each
// followed by a saturating add stage, then the output rounding register
// synchronous reset clears valid bits and sets both coefficients to 1.0
// a stall holds only full stages, so bubbles close up and req stays open while any stage is empty
`default_nettype none

module radial_distortion_with_jacobians #(
   parameter int COORD_FRAC_BITS = 20
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  rdj_pkg::rdj_req_type                    req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output rdj_pkg::rdj_rsp_type                    rsp_data,
   input  logic                                    csr_wr_en,
   input  logic [rdj_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic signed [rdj_pkg::FIELD_WIDTH-1:0]  csr_wdata
);
   import rdj_pkg::*;

   localparam int NSTAGE     = 17;
   localparam int MUL_GROUPS = 4;
   localparam int XX_LSHIFT  = (2*COORD_FRAC_BITS < INT_FRAC_BITS) ?
                               INT_FRAC_BITS - 2*COORD_FRAC_BITS : 0;
   localparam int XX_RSHIFT  = (2*COORD_FRAC_BITS > INT_FRAC_BITS) ?
                               2*COORD_FRAC_BITS - INT_FRAC_BITS : 0;
   localparam int K1X2_SHIFT = INT_FRAC_BITS - COEFF_FRAC_BITS + 1;
   localparam int K4_RSHIFT  = COEFF_FRAC_BITS - 2;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] x;
      logic signed [FIELD_WIDTH-1:0] y;
      logic signed [INT_WIDTH-1:0]   xx;
      logic signed [INT_WIDTH-1:0]   yy;
      logic signed [INT_WIDTH-1:0]   xy;
      logic signed [INT_WIDTH-1:0]   r2;
      logic signed [INT_WIDTH-1:0]   r4;
      logic signed [INT_WIDTH-1:0]   a1;
      logic signed [INT_WIDTH-1:0]   dkr;
      logic signed [INT_WIDTH-1:0]   kr;
      logic signed [INT_WIDTH-1:0]   xr2;
      logic signed [INT_WIDTH-1:0]   yr2;
      logic signed [INT_WIDTH-1:0]   xr4;
      logic signed [INT_WIDTH-1:0]   yr4;
      logic signed [INT_WIDTH-1:0]   krx;
      logic signed [INT_WIDTH-1:0]   kry;
      logic signed [INT_WIDTH-1:0]   jxx;
      logic signed [INT_WIDTH-1:0]   jxy;
      logic signed [INT_WIDTH-1:0]   jyy;
   } carry_type;

   function automatic logic signed [INT_WIDTH-1:0] sat_add(
      input logic signed [INT_WIDTH-1:0] a,
      input logic signed [INT_WIDTH-1:0] b
   );
      logic signed [INT_WIDTH:0] s;
      s = (INT_WIDTH+1)'(a) + (INT_WIDTH+1)'(b);
      if (s > (INT_WIDTH+1)'(INT_LIMIT)) begin
         return INT_LIMIT;
      end else if (s < -((INT_WIDTH+1)'(INT_LIMIT))) begin
         return -INT_LIMIT;
      end
      return s[INT_WIDTH-1:0];
   endfunction

   function automatic logic signed [OUT_WIDTH-1:0] to_out(
      input logic signed [INT_WIDTH-1:0] v
   );
      logic                            neg;
      logic [INT_WIDTH-2:0]            mag;
      logic [INT_WIDTH-OUT_SHIFT-1:0]  m;
      logic signed [OUT_WIDTH-1:0]     r;
      neg = v[INT_WIDTH-1];
      mag = neg ? (INT_WIDTH-1)'(-v) : (INT_WIDTH-1)'(v);
      m   = (INT_WIDTH-OUT_SHIFT)'(({1'b0, mag} + INT_WIDTH'(OUT_ROUND)) >> OUT_SHIFT);
      if (!neg && m > (INT_WIDTH-OUT_SHIFT)'(OUT_MAX_POS)) begin
         r = OUT_MAX_POS;
      end else if (neg && m > (INT_WIDTH-OUT_SHIFT)'(OUT_MAX_NEG)) begin
         r = OUT_MAX_NEG;
      end else begin
         r = neg ? -m[OUT_WIDTH-1:0] : m[OUT_WIDTH-1:0];
      end
      return r;
   endfunction

   logic signed [FIELD_WIDTH-1:0] k1_ff;
   logic signed [FIELD_WIDTH-1:0] k1_in;
   logic signed [FIELD_WIDTH-1:0] k2_ff;
   logic signed [FIELD_WIDTH-1:0] k2_in;
   logic signed [INT_WIDTH-1:0]   k1x2;

   logic [NSTAGE:1]   vld_ff;
   logic [NSTAGE:1]   vld_in;
   logic [NSTAGE:1]   vld_prev;
   logic [NSTAGE+1:1] en;

   carry_type   carry_ff [1:NSTAGE-1];
   carry_type   carry_in [1:NSTAGE-1];
   rdj_rsp_type rsp_ff;
   rdj_rsp_type rsp_in;

   rdj_mul_en_type mul_en [MUL_GROUPS];

   logic signed [INT_WIDTH-1:0] xx_p, yy_p, xy_p;
   logic signed [INT_WIDTH-1:0] r4_p, k1r2_p, k4r2_p, xr2_p, yr2_p;
   logic signed [INT_WIDTH-1:0] k2r4_p, xr4_p, yr4_p;
   logic signed [INT_WIDTH-1:0] krx_p, kry_p, xxd_p, xyd_p, yyd_p;

   // stall chain: a stage loads when empty or when the next one loads
   always_comb begin
      en[NSTAGE+1] = !rsp_stall;
      for (int k = NSTAGE; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_prev = {vld_ff[NSTAGE-1:1], req_valid};
      for (int k = 1; k <= NSTAGE; k++) begin
         vld_in[k] = en[k] ? vld_prev[k] : vld_ff[k];
      end
      for (int g = 0; g < MUL_GROUPS; g++) begin
         mul_en[g].prod = en[4*g+1];
         mul_en[g].sum  = en[4*g+2];
         mul_en[g].sat  = en[4*g+3];
      end
   end

   always_comb begin
      k1_in = k1_ff;
      k2_in = k2_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COEFF_K1: k1_in = csr_wdata;
            CSR_COEFF_K2: k2_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign k1x2 = INT_WIDTH'(k1_ff) <<< K1X2_SHIFT;

   // group 0: x*x, y*y, x*y
   rdj_mul #(.A_WIDTH(FIELD_WIDTH), .B_WIDTH(FIELD_WIDTH),
             .L_SHIFT(XX_LSHIFT), .R_SHIFT(XX_RSHIFT)) u_mul_xx (
      .clock(clock), .en(mul_en[0]), .a(req_data.point_x), .b(req_data.point_x), .p(xx_p));
   rdj_mul #(.A_WIDTH(FIELD_WIDTH), .B_WIDTH(FIELD_WIDTH),
             .L_SHIFT(XX_LSHIFT), .R_SHIFT(XX_RSHIFT)) u_mul_yy (
      .clock(clock), .en(mul_en[0]), .a(req_data.point_y), .b(req_data.point_y), .p(yy_p));
   rdj_mul #(.A_WIDTH(FIELD_WIDTH), .B_WIDTH(FIELD_WIDTH),
             .L_SHIFT(XX_LSHIFT), .R_SHIFT(XX_RSHIFT)) u_mul_xy (
      .clock(clock), .en(mul_en[0]), .a(req_data.point_x), .b(req_data.point_y), .p(xy_p));

   // group 1: terms in r2
   rdj_mul #(.A_WIDTH(INT_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(INT_FRAC_BITS)) u_mul_r4 (
      .clock(clock), .en(mul_en[1]), .a(carry_ff[4].r2), .b(carry_ff[4].r2), .p(r4_p));
   rdj_mul #(.A_WIDTH(FIELD_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(COEFF_FRAC_BITS)) u_mul_k1r2 (
      .clock(clock), .en(mul_en[1]), .a(k1_ff), .b(carry_ff[4].r2), .p(k1r2_p));
   rdj_mul #(.A_WIDTH(FIELD_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(K4_RSHIFT)) u_mul_k4r2 (
      .clock(clock), .en(mul_en[1]), .a(k2_ff), .b(carry_ff[4].r2), .p(k4r2_p));
   rdj_mul #(.A_WIDTH(FIELD_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(COORD_FRAC_BITS)) u_mul_xr2 (
      .clock(clock), .en(mul_en[1]), .a(carry_ff[4].x), .b(carry_ff[4].r2), .p(xr2_p));
   rdj_mul #(.A_WIDTH(FIELD_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(COORD_FRAC_BITS)) u_mul_yr2 (
      .clock(clock), .en(mul_en[1]), .a(carry_ff[4].y), .b(carry_ff[4].r2), .p(yr2_p));

   // group 2: terms in r4
   rdj_mul #(.A_WIDTH(FIELD_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(COEFF_FRAC_BITS)) u_mul_k2r4 (
      .clock(clock), .en(mul_en[2]), .a(k2_ff), .b(carry_ff[8].r4), .p(k2r4_p));
   rdj_mul #(.A_WIDTH(FIELD_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(COORD_FRAC_BITS)) u_mul_xr4 (
      .clock(clock), .en(mul_en[2]), .a(carry_ff[8].x), .b(carry_ff[8].r4), .p(xr4_p));
   rdj_mul #(.A_WIDTH(FIELD_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(COORD_FRAC_BITS)) u_mul_yr4 (
      .clock(clock), .en(mul_en[2]), .a(carry_ff[8].y), .b(carry_ff[8].r4), .p(yr4_p));

   // group 3: distorted point and point jacobian
   rdj_mul #(.A_WIDTH(FIELD_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(COORD_FRAC_BITS)) u_mul_krx (
      .clock(clock), .en(mul_en[3]), .a(carry_ff[12].x), .b(carry_ff[12].kr), .p(krx_p));
   rdj_mul #(.A_WIDTH(FIELD_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(COORD_FRAC_BITS)) u_mul_kry (
      .clock(clock), .en(mul_en[3]), .a(carry_ff[12].y), .b(carry_ff[12].kr), .p(kry_p));
   rdj_mul #(.A_WIDTH(INT_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(INT_FRAC_BITS)) u_mul_xxd (
      .clock(clock), .en(mul_en[3]), .a(carry_ff[12].xx), .b(carry_ff[12].dkr), .p(xxd_p));
   rdj_mul #(.A_WIDTH(INT_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(INT_FRAC_BITS)) u_mul_xyd (
      .clock(clock), .en(mul_en[3]), .a(carry_ff[12].xy), .b(carry_ff[12].dkr), .p(xyd_p));
   rdj_mul #(.A_WIDTH(INT_WIDTH), .B_WIDTH(INT_WIDTH),
             .L_SHIFT(0), .R_SHIFT(INT_FRAC_BITS)) u_mul_yyd (
      .clock(clock), .en(mul_en[3]), .a(carry_ff[12].yy), .b(carry_ff[12].dkr), .p(yyd_p));

   always_comb begin
      carry_in[1]   = '0;
      carry_in[1].x = req_data.point_x;
      carry_in[1].y = req_data.point_y;
      for (int k = 2; k <= NSTAGE-1; k++) begin
         carry_in[k] = carry_ff[k-1];
      end

      carry_in[4].xx  = xx_p;
      carry_in[4].yy  = yy_p;
      carry_in[4].xy  = xy_p;
      carry_in[4].r2  = sat_add(xx_p, yy_p);

      carry_in[8].r4  = r4_p;
      carry_in[8].xr2 = xr2_p;
      carry_in[8].yr2 = yr2_p;
      carry_in[8].a1  = sat_add(ONE_Q, k1r2_p);
      carry_in[8].dkr = sat_add(k1x2, k4r2_p);

      carry_in[12].xr4 = xr4_p;
      carry_in[12].yr4 = yr4_p;
      carry_in[12].kr  = sat_add(carry_ff[11].a1, k2r4_p);

      carry_in[16].krx = krx_p;
      carry_in[16].kry = kry_p;
      carry_in[16].jxy = xyd_p;
      carry_in[16].jxx = sat_add(carry_ff[15].kr, xxd_p);
      carry_in[16].jyy = sat_add(carry_ff[15].kr, yyd_p);
   end

   always_comb begin
      rsp_in.dist_x = to_out(carry_ff[NSTAGE-1].krx);
      rsp_in.dist_y = to_out(carry_ff[NSTAGE-1].kry);
      rsp_in.dx_dk1 = to_out(carry_ff[NSTAGE-1].xr2);
      rsp_in.dx_dk2 = to_out(carry_ff[NSTAGE-1].xr4);
      rsp_in.dy_dk1 = to_out(carry_ff[NSTAGE-1].yr2);
      rsp_in.dy_dk2 = to_out(carry_ff[NSTAGE-1].yr4);
      rsp_in.jac_xx = to_out(carry_ff[NSTAGE-1].jxx);
      rsp_in.jac_xy = to_out(carry_ff[NSTAGE-1].jxy);
      rsp_in.jac_yy = to_out(carry_ff[NSTAGE-1].jyy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         k1_ff  <= COEFF_RESET;
         k2_ff  <= COEFF_RESET;
      end else begin
         vld_ff <= vld_in;
         k1_ff  <= k1_in;
         k2_ff  <= k2_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= NSTAGE-1; k++) begin
         if (en[k]) begin
            carry_ff[k] <= carry_in[k];
         end
      end
      if (en[NSTAGE]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_stall = !en[1];
   assign rsp_valid = vld_ff[NSTAGE];
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/rdj_mul.sv =====
// three-stage signed fixed-point multiplier with rounding and saturation
`default_nettype none

module rdj_mul #(
   parameter int A_WIDTH = 24,
   parameter int B_WIDTH = 63,
   parameter int L_SHIFT = 0,
   parameter int R_SHIFT = 32
) (
   input  logic                                  clock,
   input  rdj_pkg::rdj_mul_en_type               en,
   input  logic signed [A_WIDTH-1:0]             a,
   input  logic signed [B_WIDTH-1:0]             b,
   output logic signed [rdj_pkg::INT_WIDTH-1:0]  p
);
   import rdj_pkg::*;

   localparam int NA = (A_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
   localparam int NB = (B_WIDTH + LIMB_WIDTH - 1) / LIMB_WIDTH;
   localparam int PW = (NA + NB) * LIMB_WIDTH;
   localparam int SW = PW + L_SHIFT;
   localparam logic [SW-1:0] HALF = (SW'(1) << R_SHIFT) >> 1;

   logic [A_WIDTH-1:0]          a_abs;
   logic [B_WIDTH-1:0]          b_abs;
   logic [NA*LIMB_WIDTH-1:0]    a_mag;
   logic [NB*LIMB_WIDTH-1:0]    b_mag;
   logic [2*LIMB_WIDTH-1:0]     pp_in [NA][NB];
   logic [2*LIMB_WIDTH-1:0]     pp_ff [NA][NB];
   logic                        neg_in;
   logic                        neg1_ff;
   logic                        neg2_ff;
   logic [PW-1:0]               prod;
   logic [SW-1:0]               sum_in;
   logic [SW-1:0]               sum_ff;
   logic [SW-1:0]               shifted;
   logic [INT_WIDTH-2:0]        mag;
   logic signed [INT_WIDTH-1:0] mag_s;
   logic signed [INT_WIDTH-1:0] p_in;
   logic signed [INT_WIDTH-1:0] p_ff;

   // partial products on magnitudes
   always_comb begin
      neg_in = a[A_WIDTH-1] ^ b[B_WIDTH-1];
      a_abs  = a[A_WIDTH-1] ? A_WIDTH'(-a) : A_WIDTH'(a);
      b_abs  = b[B_WIDTH-1] ? B_WIDTH'(-b) : B_WIDTH'(b);
      a_mag  = (NA*LIMB_WIDTH)'(a_abs);
      b_mag  = (NB*LIMB_WIDTH)'(b_abs);
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_in[i][j] = a_mag[i*LIMB_WIDTH +: LIMB_WIDTH] * b_mag[j*LIMB_WIDTH +: LIMB_WIDTH];
         end
      end
   end

   // sum with rounding constant
   always_comb begin
      prod = '0;
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            prod = prod + (PW'(pp_ff[i][j]) << (LIMB_WIDTH * (i + j)));
         end
      end
      sum_in = (SW'(prod) << L_SHIFT) + HALF;
   end

   // scale, saturate, apply sign
   always_comb begin
      shifted = sum_ff >> R_SHIFT;
      mag     = (shifted > SW'(LIMIT_MAG)) ? LIMIT_MAG : shifted[INT_WIDTH-2:0];
      mag_s   = {1'b0, mag};
      p_in    = neg2_ff ? -mag_s : mag_s;
   end

   always_ff @(posedge clock) begin
      if (en.prod) begin
         pp_ff   <= pp_in;
         neg1_ff <= neg_in;
      end
      if (en.sum) begin
         sum_ff  <= sum_in;
         neg2_ff <= neg1_ff;
      end
      if (en.sat) begin
         p_ff    <= p_in;
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

// ===== hdl/rdj_check.sv =====
// port-level checks for the radial distortion block and their binding
`default_nettype none

module rdj_check (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rdj_pkg::rdj_rsp_type  rsp_data
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // with the output free the whole pipeline moves, so input is never held
   assert property (@(posedge clock)
      !rsp_stall |-> !req_stall)
      else $error("req stalled while rsp side is free");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind radial_distortion_with_jacobians rdj_check u_rdj_check (.*);

`default_nettype wire

// ===== sim/tb_radial_distortion_with_jacobians.sv =====
// testbench for radial_distortion_with_jacobians: distortion scoreboard and stream drivers
module tb_radial_distortion_with_jacobians;
   timeunit 1ns;
   timeprecision 1ps;

   import rdj_pkg::*;

   localparam int COORD_FRAC_BITS = 20;
   localparam int PIPE_LATENCY    = 17;
   localparam int SETTINGS        = 8;
   localparam int POINTS_PER_SET  = 81;
   localparam longint QLIM        = 64'h3FFF_FFFF_FFFF_FFFF;

   class distortion_checker;
      logic signed [FIELD_WIDTH-1:0] k1;
      logic signed [FIELD_WIDTH-1:0] k2;
      rdj_rsp_type expected_q[$];
      string field_name[9];
      int unsigned points;
      int unsigned results;
      int unsigned mismatches;
      int unsigned strays;

      function new();
         k1 = COEFF_RESET;
         k2 = COEFF_RESET;
         field_name = '{"dist_x", "dist_y", "dx_dk1", "dx_dk2", "dy_dk1", "dy_dk2",
                        "jac_xx", "jac_xy", "jac_yy"};
      endfunction

      function void set_coeff(logic [CSR_INDEX_WIDTH-1:0] idx,
                              logic signed [FIELD_WIDTH-1:0] value);
         if (idx == CSR_COEFF_K1) begin
            k1 = value;
         end else if (idx == CSR_COEFF_K2) begin
            k2 = value;
         end
      endfunction

      // q.32 product, magnitude rounded half away from zero, saturated
      function longint q_mul(longint a, longint b);
         logic [63:0] ma;
         logic [63:0] mb;
         logic [127:0] prod;
         longint r;
         ma = (a < 0) ? -a : a;
         mb = (b < 0) ? -b : b;
         prod = ({64'd0, ma} * {64'd0, mb}) + 128'h8000_0000;
         prod = prod >> INT_FRAC_BITS;
         if (prod > 128'(QLIM)) begin
            prod = 128'(QLIM);
         end
         r = longint'(prod[63:0]);
         return ((a < 0) != (b < 0)) ? -r : r;
      endfunction

      function longint q_add(longint a, longint b);
         longint s;
         s = a + b;
         if (s > QLIM) begin
            s = QLIM;
         end else if (s < -QLIM) begin
            s = -QLIM;
         end
         return s;
      endfunction

      function logic [OUT_WIDTH-1:0] to_q824(longint v);
         logic [63:0] m;
         m = (v < 0) ? -v : v;
         m = (m + 64'(OUT_ROUND)) >> OUT_SHIFT;
         if (v >= 0 && m > 64'h7FFF_FFFF) begin
            m = 64'h7FFF_FFFF;
         end
         if (v < 0 && m > 64'h8000_0000) begin
            m = 64'h8000_0000;
         end
         if (v < 0) begin
            m = -m;
         end
         return m[OUT_WIDTH-1:0];
      endfunction

      function rdj_rsp_type distort_point(rdj_req_type p);
         longint px, py, c1, c2, xx, yy, xy, r2, r4, kr, dkr;
         rdj_rsp_type d;
         px = p.point_x;
         py = p.point_y;
         c1 = k1;
         c2 = k2;
         px = px << (INT_FRAC_BITS - COORD_FRAC_BITS);
         py = py << (INT_FRAC_BITS - COORD_FRAC_BITS);
         c1 = c1 << (INT_FRAC_BITS - COEFF_FRAC_BITS);
         c2 = c2 << (INT_FRAC_BITS - COEFF_FRAC_BITS);
         xx = q_mul(px, px);
         yy = q_mul(py, py);
         xy = q_mul(px, py);
         r2 = q_add(xx, yy);
         r4 = q_mul(r2, r2);
         kr = q_add(q_add(ONE_Q, q_mul(c1, r2)), q_mul(c2, r4));
         dkr = q_add(2 * c1, q_mul(4 * c2, r2));
         d.dist_x = to_q824(q_mul(kr, px));
         d.dist_y = to_q824(q_mul(kr, py));
         d.dx_dk1 = to_q824(q_mul(px, r2));
         d.dx_dk2 = to_q824(q_mul(px, r4));
         d.dy_dk1 = to_q824(q_mul(py, r2));
         d.dy_dk2 = to_q824(q_mul(py, r4));
         d.jac_xx = to_q824(q_add(kr, q_mul(xx, dkr)));
         d.jac_xy = to_q824(q_mul(xy, dkr));
         d.jac_yy = to_q824(q_add(kr, q_mul(yy, dkr)));
         return d;
      endfunction

      function void note_point(rdj_req_type p);
         expected_q.push_back(distort_point(p));
         points++;
      endfunction

      function void check_distortion(rdj_rsp_type got);
         logic [$bits(rdj_rsp_type)-1:0] gv;
         logic [$bits(rdj_rsp_type)-1:0] wv;
         if (expected_q.size() == 0) begin
            strays++;
            if (mismatches + strays <= 10) begin
               $display("unexpected result transfer at %0t: %h", $realtime, got);
            end
            return;
         end
         wv = expected_q.pop_front();
         gv = got;
         results++;
         for (int i = 0; i < 9; i++) begin
            if (gv[(8 - i) * OUT_WIDTH +: OUT_WIDTH] !== wv[(8 - i) * OUT_WIDTH +: OUT_WIDTH]) begin
               mismatches++;
               if (mismatches + strays <= 10) begin
                  $display("mismatch on %s, result %0d: expected %h got %h", field_name[i],
                           results, wv[(8 - i) * OUT_WIDTH +: OUT_WIDTH],
                           gv[(8 - i) * OUT_WIDTH +: OUT_WIDTH]);
               end
            end
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rdj_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rdj_rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic signed [FIELD_WIDTH-1:0] csr_wdata = '0;

   bit no_idle = 1'b0;
   distortion_checker board = new();

   radial_distortion_with_jacobians #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 12);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_distortion(rsp_data);
      end
   end

   task automatic send_point(input logic signed [FIELD_WIDTH-1:0] x,
                             input logic signed [FIELD_WIDTH-1:0] y);
      rdj_req_type item;
      item.point_x = x;
      item.point_y = y;
      if (!no_idle) begin
         while ($urandom_range(99) < 12) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      board.note_point(item);
   endtask

   function automatic logic signed [FIELD_WIDTH-1:0] random_coord();
      // mostly normalized points within +-1.5, the rest anywhere in range
      if ($urandom_range(2) == 0) begin
         return FIELD_WIDTH'($urandom);
      end
      return FIELD_WIDTH'(int'($urandom_range(3145728)) - 1572864);
   endfunction

   task automatic send_random_points(input int count);
      for (int i = 0; i < count; i++) begin
         send_point(random_coord(), random_coord());
      end
   endtask

   task automatic drain_pipeline();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (board.expected_q.size() != 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   // both coefficients, then a write to an unused index that must be ignored
   task automatic program_coeffs(input logic signed [FIELD_WIDTH-1:0] k1,
                                 input logic signed [FIELD_WIDTH-1:0] k2);
      logic [CSR_INDEX_WIDTH-1:0] unused_idx;
      unused_idx = CSR_INDEX_WIDTH'($urandom_range((1 << CSR_INDEX_WIDTH) - 1,
                                                   int'(CSR_COEFF_K2) + 1));
      csr_wr_en <= 1'b1;
      csr_index <= CSR_COEFF_K1;
      csr_wdata <= k1;
      @(posedge clock);
      board.set_coeff(CSR_COEFF_K1, k1);
      csr_index <= CSR_COEFF_K2;
      csr_wdata <= k2;
      @(posedge clock);
      board.set_coeff(CSR_COEFF_K2, k2);
      csr_index <= unused_idx;
      csr_wdata <= FIELD_WIDTH'($urandom);
      @(posedge clock);
      board.set_coeff(unused_idx, csr_wdata);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic signed [FIELD_WIDTH-1:0] k1_set[SETTINGS];
      logic signed [FIELD_WIDTH-1:0] k2_set[SETTINGS];
      logic signed [FIELD_WIDTH-1:0] fmax;
      logic signed [FIELD_WIDTH-1:0] fmin;
      logic signed [FIELD_WIDTH-1:0] unit;
      int unsigned leftover;
      fmax = {1'b0, {(FIELD_WIDTH - 1){1'b1}}};
      fmin = {1'b1, {(FIELD_WIDTH - 1){1'b0}}};
      unit = FIELD_WIDTH'(1) << COORD_FRAC_BITS;
      k1_set = '{COEFF_RESET, '0, fmax, fmin, fmax, fmin, '0, '0};
      k2_set = '{COEFF_RESET, '0, fmax, fmin, fmin, fmax, '0, '0};
      k1_set[6] = FIELD_WIDTH'(int'($urandom_range(1048576)) - 524288);
      k2_set[6] = FIELD_WIDTH'(int'($urandom_range(1048576)) - 524288);
      k1_set[7] = FIELD_WIDTH'($urandom);
      k2_set[7] = FIELD_WIDTH'($urandom);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // coefficients at their reset value of 1.0: field extremes, unit and lsb points, bit patterns, then random points
      send_point('0, '0);
      send_point(fmax, fmax);
      send_point(fmin, fmin);
      send_point(fmin, fmax);
      send_point(fmax, fmin);
      send_point(fmax, '0);
      send_point('0, fmin);
      send_point(1, 1);
      send_point(-1, -1);
      send_point(1, -1);
      send_point(unit, '0);
      send_point('0, -unit);
      send_point(unit, unit);
      send_point(-unit, unit);
      send_point(unit >>> 1, -(unit >>> 2));
      send_point(24'h555555, 24'hAAAAAA);
      send_point(24'hAAAAAA, 24'h555555);
      send_point(-1, fmax);
      send_random_points(POINTS_PER_SET);

      for (int s = 1; s < SETTINGS; s++) begin
         drain_pipeline();
         program_coeffs(k1_set[s], k2_set[s]);
         if (s == 3) begin
            no_idle = 1'b1;
         end
         send_point(fmax, fmin);
         send_random_points(POINTS_PER_SET);
         no_idle = 1'b0;
      end

      drain_pipeline();
      leftover = board.expected_q.size();
      if (leftover != 0) begin
         $display("%0d expected results never arrived", leftover);
      end
      $display("checked %0d of %0d point transfers across %0d coefficient settings",
               board.results, board.points, SETTINGS);
      $display("including saturating coefficients, extreme coordinates and ignored csr writes");
      if (board.mismatches == 0 && board.strays == 0 && leftover == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d field mismatches, %0d unexpected results", board.mismatches,
                  board.strays);
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout waiting for transfers");
      $display("TEST FAILED");
      $finish;
   end

endmodule
